/* rtl/bes_pkg.sv */
`timescale 1ns / 1ps

package bes_pkg;

    localparam int MAX_DEPTH    = 255;
    localparam int LENGTH_WIDTH = 32;
    localparam int DEPTH_WIDTH  = $clog2(MAX_DEPTH + 1);
    localparam int PROD_WIDTH   = LENGTH_WIDTH + 4;

    localparam logic [7:0] CH_DICT  = 8'h64;   // 'd'
    localparam logic [7:0] CH_LIST  = 8'h6c;   // 'l'
    localparam logic [7:0] CH_INT   = 8'h69;   // 'i'
    localparam logic [7:0] CH_END   = 8'h65;   // 'e'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CH_COLON = 8'h3a;   // ':'

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_LEN  = 2'd2,
        MODE_BODY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_DONE   = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                    mode;
        logic [DEPTH_WIDTH-1:0]   depth;
        logic [LENGTH_WIDTH-1:0]  len;
    } bes_state_t;

endpackage

/* rtl/bencode_element_skipper.sv */
`timescale 1ns / 1ps
// A byte is accepted into the input register, and its result word is then registered
// in the result register; an output stall can hold the byte in the input register.
// Throughput: one byte per cycle while out_stall is low.
// Reset (rst_n low, asynchronous) returns the parser to idle at depth zero
// and empties both pipeline registers.
module bencode_element_skipper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] nesting_level
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [7:0]           out_nest_reg;
    bes_pkg::bes_state_t  state_reg;
    bes_pkg::bes_state_t  state_next;
    bes_pkg::status_t     step_status;
    logic                 advance;
    logic                 in_take;

    bes_step u_step
    (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .status    (step_status)
    );

    // The held byte moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: bes_pkg::MODE_IDLE, depth: '0, len: '0};
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance)
        begin
            out_status_reg <= step_status;
            out_nest_reg   <= 8'(state_next.depth);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign nesting_level = out_nest_reg;

endmodule

/* rtl/bes_step.sv */
`timescale 1ns / 1ps

module bes_step
(
    input  bes_pkg::bes_state_t cur,
    input  logic [7:0]          data_byte,
    output bes_pkg::bes_state_t nxt,
    output bes_pkg::status_t    status
);

    logic                                digit;
    logic [3:0]                          digit_val;
    logic [bes_pkg::PROD_WIDTH-1:0]      len_wide;
    logic [bes_pkg::PROD_WIDTH-1:0]      len_times10;
    logic                                len_ovf;
    logic [bes_pkg::LENGTH_WIDTH-1:0]    len_dec;
    logic [bes_pkg::DEPTH_WIDTH-1:0]     depth_dec;

    assign digit     = (data_byte >= bes_pkg::CH_ZERO) && (data_byte <= bes_pkg::CH_NINE);
    assign digit_val = 4'(data_byte - bes_pkg::CH_ZERO);
    assign len_wide  = bes_pkg::PROD_WIDTH'(cur.len);

    // Length times ten plus the new digit; any carry above the length width is an overflow.
    assign len_times10 = (len_wide << 3) + (len_wide << 1)
                       + bes_pkg::PROD_WIDTH'(digit_val);
    assign len_ovf     = |len_times10[bes_pkg::PROD_WIDTH-1:bes_pkg::LENGTH_WIDTH];

    assign len_dec   = (cur.len != '0) ? cur.len - 1'b1 : cur.len;
    assign depth_dec = cur.depth - 1'b1;

    always_comb
    begin
        nxt    = cur;
        status = bes_pkg::ST_INSIDE;
        case (cur.mode)
            bes_pkg::MODE_IDLE:
            begin
                if (data_byte == bes_pkg::CH_DICT || data_byte == bes_pkg::CH_LIST)
                begin
                    if (cur.depth >= bes_pkg::DEPTH_WIDTH'(bes_pkg::MAX_DEPTH))
                    begin
                        nxt    = '{mode: bes_pkg::MODE_IDLE, depth: '0, len: '0};
                        status = bes_pkg::ST_ERROR;
                    end
                    else
                    begin
                        nxt.depth = cur.depth + 1'b1;
                    end
                end
                else if (data_byte == bes_pkg::CH_INT)
                begin
                    nxt.mode = bes_pkg::MODE_INT;
                end
                else if (digit)
                begin
                    nxt.mode = bes_pkg::MODE_LEN;
                    nxt.len  = bes_pkg::LENGTH_WIDTH'(digit_val);
                end
                else if (data_byte == bes_pkg::CH_END && cur.depth != '0)
                begin
                    nxt.mode  = bes_pkg::MODE_IDLE;
                    nxt.depth = depth_dec;
                    nxt.len   = '0;
                    status    = (depth_dec == '0) ? bes_pkg::ST_DONE : bes_pkg::ST_INSIDE;
                end
                else
                begin
                    // A close at depth zero or a byte that cannot start a value.
                    nxt    = '{mode: bes_pkg::MODE_IDLE, depth: '0, len: '0};
                    status = bes_pkg::ST_ERROR;
                end
            end
            bes_pkg::MODE_INT:
            begin
                if (data_byte == bes_pkg::CH_END)
                begin
                    nxt.mode = bes_pkg::MODE_IDLE;
                    nxt.len  = '0;
                    status   = (cur.depth == '0) ? bes_pkg::ST_DONE : bes_pkg::ST_INSIDE;
                end
            end
            bes_pkg::MODE_LEN:
            begin
                if (digit && !len_ovf)
                begin
                    nxt.len = len_times10[bes_pkg::LENGTH_WIDTH-1:0];
                end
                else if (data_byte == bes_pkg::CH_COLON)
                begin
                    if (cur.len == '0)
                    begin
                        nxt.mode = bes_pkg::MODE_IDLE;
                        status   = (cur.depth == '0) ? bes_pkg::ST_DONE : bes_pkg::ST_INSIDE;
                    end
                    else
                    begin
                        nxt.mode = bes_pkg::MODE_BODY;
                    end
                end
                else
                begin
                    nxt    = '{mode: bes_pkg::MODE_IDLE, depth: '0, len: '0};
                    status = bes_pkg::ST_ERROR;
                end
            end
            bes_pkg::MODE_BODY:
            begin
                nxt.len = len_dec;
                if (len_dec == '0)
                begin
                    nxt.mode = bes_pkg::MODE_IDLE;
                    status   = (cur.depth == '0) ? bes_pkg::ST_DONE : bes_pkg::ST_INSIDE;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* rtl/bes_checker.sv */
`timescale 1ns / 1ps

module bes_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] nesting_level
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(nesting_level))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != bes_pkg::ST_ERROR + 2'd1)
        else $error("status carries an unused code");

    // Completion and error both leave the parser at the top level.
    a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bes_pkg::ST_DONE || status == bes_pkg::ST_ERROR)
        |-> nesting_level == 8'd0)
        else $error("nonzero depth on completion or error");

    // No word can come out without a byte having been taken into the input register first.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) && !$past(in_stall, 2))
        else $error("result word without an accepted byte");

endmodule

bind bencode_element_skipper bes_checker u_bes_checker (.*);
